FILE: hdl/page_frame_allocator_defines.svh
// Assertion macros for the allocator's top-level file.
`ifndef PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define PFA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pfa_pkg.sv
package pfa_pkg;

	localparam int NUM_PAGES_DEF = 1024;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 32;
	localparam int NEED_W = SIZE_W + 1 - PAGE_SHIFT;
	localparam int PAGE_COUNT_W = 11;
	localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RESET = 11'd1024;
	localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = 32'd0;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_PAGES  = 2'd1,
		STATUS_ZERO_SIZE = 2'd2,
		STATUS_BAD_ADDR  = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic {
		CFG_PAGE_COUNT   = 1'b0,
		CFG_BASE_ADDRESS = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_TAIL,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] head;
		status_t           status;
	} res_t;

endpackage

FILE: hdl/pfa_ram.sv
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/pfa_ctrl.sv
module pfa_ctrl import pfa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF,
	localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
	localparam int CW = $clog2(NUM_PAGES + 1),
	localparam int WW = CW + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear_start,
	input  logic [CW-1:0]     active_count,
	input  logic [ADDR_W-1:0] base_address,
	input  logic              in_take,
	input  logic              in_func,
	input  logic [SIZE_W-1:0] in_size,
	input  logic [ADDR_W-1:0] in_address,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_take,
	output res_t              res,
	output logic              ram_we,
	output logic [IW-1:0]     ram_waddr,
	output logic [WW-1:0]     ram_wdata,
	output logic              ram_re,
	output logic [IW-1:0]     ram_raddr,
	input  logic [WW-1:0]     ram_rdata
);

	state_t state_q, state_d;
	logic [IW-1:0] clr_q, clr_d;
	logic [CW-1:0] free_q, free_d;
	func_t func_q, func_d;
	logic [NEED_W-1:0] need_q, need_d;
	logic zero_q, zero_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [CW-1:0] scan_q, scan_d;
	logic rd_vld_s1, rd_vld_d;
	logic [IW-1:0] rd_idx_s1;
	logic have_head_q, have_head_d;
	logic [IW-1:0] prev_q, prev_d;
	logic [ADDR_W-1:0] head_q, head_d;
	logic [IW-1:0] walk_q, walk_d;
	res_t res_q, res_d;

	logic [SIZE_W:0] size_round;
	logic [ADDR_W-1:0] off;
	logic [ADDR_W-1:0] off_page;
	logic rd_used;
	logic [CW-1:0] rd_link;
	logic [CW-1:0] link_m1;

	assign size_round = {1'b0, in_size} + (SIZE_W + 1)'(PAGE_BYTES - 1);
	assign off = addr_q - base_address;
	assign off_page = off >> PAGE_SHIFT;
	assign rd_used = ram_rdata[WW-1];
	assign rd_link = ram_rdata[CW-1:0];
	assign link_m1 = rd_link - CW'(1);

	assign idle = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			rd_vld_s1 <= rd_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		free_q <= free_d;
		func_q <= func_d;
		need_q <= need_d;
		zero_q <= zero_d;
		addr_q <= addr_d;
		scan_q <= scan_d;
		rd_idx_s1 <= scan_q[IW-1:0];
		have_head_q <= have_head_d;
		prev_q <= prev_d;
		head_q <= head_d;
		walk_q <= walk_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		free_d = free_q;
		func_d = func_q;
		need_d = need_q;
		zero_d = zero_q;
		addr_d = addr_q;
		scan_d = scan_q;
		rd_vld_d = 1'b0;
		have_head_d = have_head_q;
		prev_d = prev_q;
		head_d = head_q;
		walk_d = walk_q;
		res_d = res_q;
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = '0;

		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == IW'(NUM_PAGES - 1)) begin
					free_d = active_count;
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + IW'(1);
				end
			end
			ST_IDLE: begin
				if (in_take) begin
					func_d = func_t'(in_func);
					need_d = size_round[SIZE_W:PAGE_SHIFT];
					zero_d = (in_size == '0);
					addr_d = in_address;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				res_d.head = '0;
				res_d.status = STATUS_OK;
				if (func_q == FUNC_ALLOC) begin
					if (zero_q) begin
						res_d.status = STATUS_ZERO_SIZE;
						state_d = ST_DONE;
					end else if (32'(need_q) > 32'(free_q)) begin
						res_d.status = STATUS_NO_PAGES;
						state_d = ST_DONE;
					end else begin
						scan_d = '0;
						have_head_d = 1'b0;
						state_d = ST_SCAN;
					end
				end else begin
					if ((off[PAGE_SHIFT-1:0] != '0) || (off_page >= 32'(active_count))) begin
						res_d.status = STATUS_BAD_ADDR;
						state_d = ST_DONE;
					end else begin
						ram_re = 1'b1;
						ram_raddr = off_page[IW-1:0];
						walk_d = off_page[IW-1:0];
						state_d = ST_WALK;
					end
				end
			end
			ST_SCAN: begin
				if (scan_q < active_count) begin
					ram_re = 1'b1;
					ram_raddr = scan_q[IW-1:0];
					rd_vld_d = 1'b1;
					scan_d = scan_q + CW'(1);
				end
				if (rd_vld_s1 && !rd_used) begin
					need_d = need_q - NEED_W'(1);
					free_d = free_q - CW'(1);
					prev_d = rd_idx_s1;
					if (!have_head_q) begin
						have_head_d = 1'b1;
						head_d = base_address + (ADDR_W'(rd_idx_s1) << PAGE_SHIFT);
					end else begin
						ram_we = 1'b1;
						ram_waddr = prev_q;
						ram_wdata = {1'b1, CW'(rd_idx_s1) + CW'(1)};
					end
					if (need_q == NEED_W'(1)) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_TAIL: begin
				ram_we = 1'b1;
				ram_waddr = prev_q;
				ram_wdata = {1'b1, CW'(0)};
				res_d.head = head_q;
				res_d.status = STATUS_OK;
				state_d = ST_DONE;
			end
			ST_WALK: begin
				ram_we = 1'b1;
				ram_waddr = walk_q;
				if (rd_used) begin
					free_d = free_q + CW'(1);
				end
				if ((rd_link == '0) || (link_m1 >= active_count)) begin
					state_d = ST_DONE;
				end else begin
					ram_re = 1'b1;
					ram_raddr = link_m1[IW-1:0];
					walk_d = link_m1[IW-1:0];
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (clear_start) begin
			state_d = ST_CLEAR;
			clr_d = '0;
		end
	end

endmodule

FILE: hdl/page_frame_allocator.sv
// Order of work: a word is checked first; an error answer is then ready, a free walks its
// chain frame by frame, and an allocate scans the frame table before it answers.
// Throughput: one word at a time; the scan and the chain walk each pass one table entry
// per cycle through the frame table.
// Reset and every page_count write start a clearing pass that zeroes the frame table; no
// word is taken during it, and on reset the registers return to their defaults.
`include "page_frame_allocator_defines.svh"

module page_frame_allocator import pfa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [ADDR_W-1:0]       cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    func,
	input  logic [SIZE_W-1:0]       size_bytes,
	input  logic                    zero_fill,
	input  logic [ADDR_W-1:0]       address,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [ADDR_W-1:0]       head_address,
	output logic [1:0]              status
);

	localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CW = $clog2(NUM_PAGES + 1);
	localparam int WW = CW + 1;

	logic [PAGE_COUNT_W-1:0] page_count_q;
	logic [ADDR_W-1:0] base_address_q;
	logic [CW-1:0] active_count;
	logic clear_start;
	logic idle;
	logic in_take;
	logic res_valid;
	logic res_take;
	res_t res;
	logic out_valid_q;
	res_t out_q;
	logic ram_we;
	logic [IW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic ram_re;
	logic [IW-1:0] ram_raddr;
	logic [WW-1:0] ram_rdata;

	assign active_count = (32'(page_count_q) > 32'(NUM_PAGES)) ?
		CW'(NUM_PAGES) : CW'(page_count_q);
	assign clear_start = cfg_we && (cfg_index == CFG_PAGE_COUNT);
	assign in_stall = !idle;
	assign in_take = in_valid && idle;
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= PAGE_COUNT_RESET;
			base_address_q <= BASE_ADDRESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGE_COUNT: page_count_q <= cfg_data[PAGE_COUNT_W-1:0];
				CFG_BASE_ADDRESS: base_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign head_address = out_q.head;
	assign status = out_q.status;

	pfa_ctrl #(
		.NUM_PAGES(NUM_PAGES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.clear_start(clear_start),
		.active_count(active_count),
		.base_address(base_address_q),
		.in_take(in_take),
		.in_func(func),
		.in_size(size_bytes),
		.in_address(address),
		.idle(idle),
		.res_valid(res_valid),
		.res_take(res_take),
		.res(res),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	pfa_ram #(
		.WIDTH(WW),
		.DEPTH(NUM_PAGES)
	) u_frame_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	`PFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "Word taken while busy.")
	`PFA_ASSERT_NEXT(a_clear_blocks_input, clear_start, in_stall, "Word taken while clearing.")
	`PFA_ASSERT_SAME(a_error_head_zero, out_valid && (status != STATUS_OK), head_address == '0, "Error head nonzero.")

endmodule

FILE: test/page_frame_allocator_checker.sv
`timescale 1ns / 100ps

module page_frame_allocator_checker import pfa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              func,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic              zero_fill,
	input  logic [ADDR_W-1:0] address,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [ADDR_W-1:0] head_address,
	input  logic [1:0]        status,
	output int                fail_count,
	output int                outstanding
);

	logic                    frame_used [NUM_PAGES];
	// Successor frame index plus one; zero ends the chain.
	logic [PAGE_COUNT_W-1:0] next_frame [NUM_PAGES];
	int unsigned             frames_free;
	logic [PAGE_COUNT_W-1:0] pages_reg;
	logic [ADDR_W-1:0]       base_reg;
	res_t                    expected_words [$];
	int                      errors = 0;

	function automatic int unsigned frames_managed();
		return (pages_reg > NUM_PAGES) ? NUM_PAGES : pages_reg;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < NUM_PAGES; i++) begin
			frame_used[i] = 1'b0;
			next_frame[i] = '0;
		end
		frames_free = frames_managed();
	endfunction

	function automatic res_t allocate_frames(logic [SIZE_W-1:0] nbytes);
		res_t            r;
		longint unsigned need;
		int unsigned     limit;
		int unsigned     prev;
		bit              have_head;
		r.head = '0;
		r.status = STATUS_OK;
		limit = frames_managed();
		prev = 0;
		have_head = 1'b0;
		if (nbytes == '0) begin
			r.status = STATUS_ZERO_SIZE;
		end else begin
			need = ({32'd0, nbytes} + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
			if (need > frames_free) begin
				r.status = STATUS_NO_PAGES;
			end else begin
				for (int unsigned i = 0; i < limit && need > 0; i++) begin
					if (!frame_used[i]) begin
						frame_used[i] = 1'b1;
						next_frame[i] = '0;
						if (!have_head) begin
							have_head = 1'b1;
							r.head = base_reg + (ADDR_W'(i) << PAGE_SHIFT);
						end else begin
							next_frame[prev] = PAGE_COUNT_W'(i + 1);
						end
						prev = i;
						need--;
						frames_free--;
					end
				end
			end
		end
		return r;
	endfunction

	function automatic res_t release_chain(logic [ADDR_W-1:0] addr);
		res_t              r;
		logic [ADDR_W-1:0] offset;
		int unsigned       idx;
		int unsigned       nxt;
		int unsigned       limit;
		int unsigned       steps;
		bit                walking;
		r.head = '0;
		r.status = STATUS_OK;
		limit = frames_managed();
		offset = addr - base_reg;
		idx = offset >> PAGE_SHIFT;
		if (offset[PAGE_SHIFT-1:0] != '0 || idx >= limit) begin
			r.status = STATUS_BAD_ADDR;
		end else begin
			steps = 0;
			walking = 1'b1;
			while (walking && steps < NUM_PAGES) begin
				nxt = next_frame[idx];
				if (frame_used[idx]) begin
					frame_used[idx] = 1'b0;
					frames_free++;
				end
				next_frame[idx] = '0;
				steps++;
				if (nxt == 0 || nxt - 1 >= limit) begin
					walking = 1'b0;
				end else begin
					idx = nxt - 1;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			pages_reg = PAGE_COUNT_RESET;
			base_reg = BASE_ADDRESS_RESET;
			wipe_table();
			expected_words.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected result word: head %h status %0d",
						head_address, status));
				end else begin
					want = expected_words.pop_front();
					if (head_address !== want.head) begin
						report_mismatch($sformatf("head_address %h, expected %h",
							head_address, want.head));
					end
					if (status !== want.status) begin
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_PAGE_COUNT) begin
					pages_reg = cfg_data[PAGE_COUNT_W-1:0];
					wipe_table();
				end else begin
					base_reg = cfg_data;
				end
			end
			if (in_valid && !in_stall) begin
				if (func == FUNC_ALLOC) begin
					expected_words.push_back(allocate_frames(size_bytes));
				end else begin
					expected_words.push_back(release_chain(address));
				end
			end
		end
		fail_count <= errors;
		outstanding <= expected_words.size();
	end

endmodule

FILE: test/page_frame_allocator_tb.sv
`timescale 1ns / 100ps

module page_frame_allocator_tb;
	import pfa_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int END_CYCLES = 1100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [ADDR_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              func = 1'b0;
	logic [SIZE_W-1:0] size_bytes = '0;
	logic              zero_fill = 1'b0;
	logic [ADDR_W-1:0] address = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ADDR_W-1:0] head_address;
	logic [1:0]        status;
	int                fail_count;
	int                outstanding;

	int                holds_wanted = 0;
	int                holds_done = 0;
	bit                quiet = 1'b0;
	int                cycle_count = 0;
	logic [10:0]       cur_pages = PAGE_COUNT_RESET;
	logic [ADDR_W-1:0] cur_base = BASE_ADDRESS_RESET;
	func_t             sent_funcs [$];
	logic [ADDR_W-1:0] live_heads [$];
	func_t             done_func;

	page_frame_allocator dut (.*);

	page_frame_allocator_checker frame_check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Heads of chains that are still allocated give the free words their targets.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall && sent_funcs.size() > 0) begin
			done_func = sent_funcs.pop_front();
			if (done_func == FUNC_ALLOC && status == STATUS_OK) begin
				live_heads.push_back(head_address);
			end
		end
	end

	initial begin
		int stall_cycles;
		wait (arst_n);
		forever begin
			if (holds_done != holds_wanted) begin
				holds_done++;
				out_stall <= 1'b1;
				stall_cycles = 0;
				while (stall_cycles < HOLD_CYCLES) begin
					@(posedge clk);
					stall_cycles++;
				end
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("page_frame_allocator_tb NOT OK");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] page_addr(int unsigned idx);
		return cur_base + (ADDR_W'(idx) << PAGE_SHIFT);
	endfunction

	task automatic issue(input func_t f, input logic [SIZE_W-1:0] sz, input logic zf,
			input logic [ADDR_W-1:0] ad);
		in_valid <= 1'b1;
		func <= f;
		size_bytes <= sz;
		zero_fill <= zf;
		address <= ad;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_funcs.push_back(f);
	endtask

	task automatic pause_sender(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_config(input logic [10:0] pages, input logic [ADDR_W-1:0] base,
			input bit set_pages);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BASE_ADDRESS;
		cfg_data <= base;
		cur_base = base;
		@(posedge clk);
		if (set_pages) begin
			cfg_index <= CFG_PAGE_COUNT;
			cfg_data <= {21'd0, pages};
			cur_pages = pages;
			live_heads.delete();
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_word();
		int unsigned       r;
		int unsigned       span;
		int unsigned       pick;
		logic [SIZE_W-1:0] sz;
		logic [ADDR_W-1:0] ad;
		span = (cur_pages > NUM_PAGES_DEF) ? NUM_PAGES_DEF : cur_pages;
		if ($urandom_range(0, 99) < (live_heads.size() == 0 ? 30 : 55)) begin
			r = $urandom_range(0, 99);
			if (r < 40 && live_heads.size() == 0) begin
				r = 50;
			end
			if (r < 40) begin
				pick = $urandom_range(0, live_heads.size() - 1);
				ad = live_heads[pick];
				live_heads.delete(pick);
			end else if (r < 70) begin
				ad = page_addr($urandom_range(0, (span == 0) ? 0 : span - 1));
			end else if (r < 80) begin
				ad = page_addr($urandom_range(0, span)) + $urandom_range(1, PAGE_BYTES - 1);
			end else if (r < 90) begin
				ad = page_addr(span + $urandom_range(0, 40));
			end else begin
				ad = $urandom;
			end
			issue(FUNC_FREE, $urandom, 1'($urandom_range(0, 1)), ad);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				sz = '0;
			end else if (r < 10) begin
				sz = $urandom;
			end else if (r < 15) begin
				sz = SIZE_W'($urandom_range(1, span + 1)) << PAGE_SHIFT;
			end else begin
				sz = $urandom_range(1, 4 * PAGE_BYTES);
			end
			issue(FUNC_ALLOC, sz, 1'($urandom_range(0, 1)), $urandom);
		end
	endtask

	task automatic run_phase(input int words, input bit hold, input bit pause);
		for (int k = 0; k < words; k++) begin
			if (hold && k == words / 3) begin
				holds_wanted++;
			end
			if (pause && k == words / 2) begin
				drain();
			end
			if (!quiet && $urandom_range(0, 3) == 0) begin
				pause_sender($urandom_range(1, 17));
			end
			random_word();
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] b;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		b = 32'h0010_0000;
		write_config(11'd8, b, 1'b1);
		issue(FUNC_ALLOC, 32'd0, 1'b0, $urandom);
		issue(FUNC_ALLOC, 32'd1, 1'b0, $urandom);
		issue(FUNC_ALLOC, 32'd4096, 1'b1, $urandom);
		issue(FUNC_ALLOC, 32'd4097, 1'b0, $urandom);
		issue(FUNC_ALLOC, 32'hFFFF_FFFF, 1'b0, $urandom);
		issue(FUNC_FREE, $urandom, 1'b0, b + 32'd1);
		issue(FUNC_FREE, $urandom, 1'b0, b + 32'd8 * PAGE_BYTES);
		issue(FUNC_FREE, $urandom, 1'b0, b - PAGE_BYTES);
		issue(FUNC_FREE, $urandom, 1'b0, 32'hFFFF_FFFF);
		// Freeing the tail of a chain, then the same frame again once it is free.
		issue(FUNC_FREE, $urandom, 1'b0, b + 32'd3 * PAGE_BYTES);
		issue(FUNC_FREE, $urandom, 1'b1, b + 32'd3 * PAGE_BYTES);
		issue(FUNC_FREE, $urandom, 1'b0, b + 32'd1 * PAGE_BYTES);
		issue(FUNC_ALLOC, 32'd3 * PAGE_BYTES, 1'b1, $urandom);
		issue(FUNC_ALLOC, 32'd5 * PAGE_BYTES, 1'b0, $urandom);
		issue(FUNC_ALLOC, 32'd3 * PAGE_BYTES, 1'b0, $urandom);
		issue(FUNC_ALLOC, 32'd1, 1'b0, $urandom);
		// The stale link of frame two leads into a chain that was built later.
		issue(FUNC_FREE, $urandom, 1'b0, b + 32'd2 * PAGE_BYTES);
		issue(FUNC_FREE, $urandom, 1'b0, b);
		issue(FUNC_FREE, $urandom, 1'b0, b + 32'd1 * PAGE_BYTES);
		issue(FUNC_FREE, $urandom, 1'b0, b + 32'd5 * PAGE_BYTES);
		issue(FUNC_ALLOC, 32'd8 * PAGE_BYTES, 1'b0, $urandom);
		issue(FUNC_FREE, $urandom, 1'b0, b);

		write_config(11'd16, $urandom & 32'hFFFF_F000, 1'b1);
		run_phase(180, 1'b0, 1'b1);
		write_config(11'd1024, 32'd0, 1'b1);
		run_phase(180, 1'b1, 1'b0);
		write_config(11'd2047, 32'hFFFF_F000, 1'b1);
		run_phase(180, 1'b0, 1'b0);
		write_config(11'd0, $urandom, 1'b1);
		run_phase(60, 1'b0, 1'b0);
		write_config(11'd1, $urandom & 32'hFFFF_F000, 1'b1);
		run_phase(140, 1'b0, 1'b1);
		write_config(11'($urandom_range(2, 64)), $urandom, 1'b1);
		run_phase(180, 1'b1, 1'b0);
		write_config(cur_pages, $urandom & 32'hFFFF_F000, 1'b0);
		run_phase(180, 1'b0, 1'b0);
		write_config(11'($urandom_range(2, 200)), $urandom & 32'hFFFF_F000, 1'b1);
		run_phase(90, 1'b0, 1'b0);
		quiet = 1'b1;
		run_phase(90, 1'b0, 1'b0);

		drain();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("page_frame_allocator_tb OK");
		end else begin
			$display("page_frame_allocator_tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pfa_pkg.sv
hdl/pfa_ram.sv
hdl/pfa_ctrl.sv
hdl/page_frame_allocator.sv
test/page_frame_allocator_checker.sv
test/page_frame_allocator_tb.sv
